// ===== design/selm_pkg.sv =====
// Package for the shared/exclusive lock manager.
// Sizes, codes, item and state types shared by the design files that import it.
package selm_pkg;

  localparam int NUM_ENTRIES  = 8;
  localparam int HOLDER_DEPTH = 16;
  localparam int WAIT_DEPTH   = 8;

  localparam int EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int HCW = $clog2(HOLDER_DEPTH + 1);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int IW  = (HCW > WCW) ? HCW : WCW;
  localparam int HAW = (NUM_ENTRIES * HOLDER_DEPTH > 1) ?
                       $clog2(NUM_ENTRIES * HOLDER_DEPTH) : 1;
  localparam int WAW = (NUM_ENTRIES * WAIT_DEPTH > 1) ?
                       $clog2(NUM_ENTRIES * WAIT_DEPTH) : 1;
  localparam int RMW = $clog2(WAIT_DEPTH + 3);

  typedef logic [15:0] id_t;

  typedef enum logic [2:0] {
    CMD_SLOCK   = 3'd0,
    CMD_SREG    = 3'd1,
    CMD_SUNLOCK = 3'd2,
    CMD_XLOCK   = 3'd3,
    CMD_XUNLOCK = 3'd4,
    CMD_ABORT   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EV_GRANTED    = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_IGNORED    = 3'd2,
    EV_EXEMPT     = 3'd3,
    EV_TABLE_FULL = 3'd4,
    EV_QUEUE_FULL = 3'd5,
    EV_WAKE       = 3'd6,
    EV_ABORTED    = 3'd7
  } ev_t;

  // command class assigned by the front end
  typedef enum logic [2:0] {
    K_EXEMPT, K_IGNORE, K_SLOCK, K_SREG, K_SUNLOCK, K_XLOCK, K_XUNLOCK, K_ABORT
  } kind_t;

  typedef struct packed {
    kind_t kind;
    id_t   id;
    id_t   lk;
  } item_t;

  typedef enum logic [1:0] {L_HOLD, L_EXW, L_SHW} lst_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_DEC, S_ACK, S_SCAN_RD, S_SCAN_CHK, S_SCAN_DONE,
    S_SH_RD, S_SH_WR, S_XPOP, S_XPOP_RD, S_XPOP_W, S_MV, S_MV_RD, S_MV_WR,
    S_AB_S, S_AB_E, S_FREE
  } state_t;

endpackage

// ===== design/selm_if.sv =====
// Channel interfaces of the lock manager: command, result, configuration.
// Stand-alone; no package needed.
interface selm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] msg_id;
  logic [15:0] lock_name;
  modport source(output valid, cmd, msg_id, lock_name, input ready);
  modport sink(input valid, cmd, msg_id, lock_name, output ready);
endinterface

interface selm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] who;
  logic [15:0] which_lock;
  logic        last;
  modport source(output valid, event_res, who, which_lock, last, input ready);
  modport sink(input valid, event_res, who, which_lock, last, output ready);
endinterface

interface selm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== design/shared_exclusive_lock_manager_unit.sv =====
// Shared/exclusive lock manager, top level.
// Uses selm_pkg, selm_if, selm_front and selm_back.
//
// Channels: in_ch takes commands (cmd, msg_id, lock_name) on valid/ready.
// out_ch returns result transactions: first an acknowledge, then any wake
// or abort results; last marks the final transaction of a command.
// cfg_ch writes the exempt lock name; it is always ready.
// Sequencing: a simple command (lock, register, exempt, ignored) finishes
// with its acknowledge. Unlock and abort walk the id lists in RAM element
// by element: scans for the id, compaction of a list over the gap, and
// one wake result per woken waiter.
// One command is processed at a time by the back end sequencer; the front
// queue holds two more, so the sender is held off only once it is full.
// Reset: table empty, all counts zero, exempt name zero; no clearing pass.
// A stalled receiver holds the result register; the sequencer waits on it
// and the front queue keeps accepting until it is full.
module shared_exclusive_lock_manager_unit import selm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  selm_in_if.sink    in_ch,
  selm_out_if.source out_ch,
  selm_cfg_if.sink   cfg_ch
);

  logic  q_valid, q_ready;
  item_t q_item;

  // classify and buffer commands
  selm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready)
  );

  // table, wait lists and result sequencing
  selm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_ready(q_ready),
    .out_ch (out_ch)
  );

endmodule

// ===== design/selm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module selm_ram #(
  parameter int W = 16,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/selm_front.sv =====
// Front end: exempt-name register, command classification, two-deep queue.
// Uses selm_pkg and the channel interfaces.
module selm_front import selm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  selm_in_if.sink    in_ch,
  selm_cfg_if.sink   cfg_ch,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  id_t        exempt_r;
  item_t      buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push, pop;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (cnt_r != 2'd2);
  assign q_valid      = (cnt_r != 2'd0);
  assign q_item       = buf_r[rp_r];
  assign push         = in_ch.valid && in_ch.ready;
  assign pop          = q_valid && q_ready;

  always_comb begin
    cls.id = in_ch.msg_id;
    cls.lk = in_ch.lock_name;
    unique case (in_ch.cmd)
      CMD_SLOCK:   cls.kind = (in_ch.lock_name == exempt_r) ? K_EXEMPT : K_SLOCK;
      CMD_SREG:    cls.kind = (in_ch.lock_name == exempt_r) ? K_EXEMPT : K_SREG;
      CMD_SUNLOCK: cls.kind = (in_ch.lock_name == exempt_r) ? K_EXEMPT : K_SUNLOCK;
      CMD_XLOCK:   cls.kind = (in_ch.msg_id == '0) ? K_IGNORE : K_XLOCK;
      CMD_XUNLOCK: cls.kind = (in_ch.msg_id == '0) ? K_IGNORE : K_XUNLOCK;
      CMD_ABORT:   cls.kind = K_ABORT;
      default:     cls.kind = K_IGNORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exempt_r <= '0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        exempt_r <= cfg_ch.data;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= cls;
    end
  end

endmodule

// ===== design/selm_back.sv =====
// Back end: lock table, id stores in RAM, command sequencer, result register.
// Uses selm_pkg, selm_ram and the result interface.
module selm_back import selm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_ready,
  selm_out_if.source out_ch
);

  state_t st_r, st_nxt, ack_ret_r, ack_ret_nxt, sh_ret_r, sh_ret_nxt;
  item_t  cur_r, cur_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic   hit_r, hit_nxt, tf_r, tf_nxt;
  lst_t   lst_r, lst_nxt;
  logic [IW-1:0] idx_r, idx_nxt, end_r, end_nxt, gap_r, gap_nxt, nm_r, nm_nxt;
  logic [IW-1:0] is_r, is_nxt, ie_r, ie_nxt;
  logic   found_r, found_nxt, fs_r, fs_nxt, fe_r, fe_nxt, wake_r, wake_nxt;
  logic [RMW-1:0] rem_r, rem_nxt;
  ev_t    ack_r, ack_nxt;

  logic           used_r [NUM_ENTRIES];
  logic           used_nxt [NUM_ENTRIES];
  id_t            key_r [NUM_ENTRIES];
  id_t            key_nxt [NUM_ENTRIES];
  id_t            own_r [NUM_ENTRIES];
  id_t            own_nxt [NUM_ENTRIES];
  logic [HCW-1:0] hc_r [NUM_ENTRIES];
  logic [HCW-1:0] hc_nxt [NUM_ENTRIES];
  logic [WCW-1:0] ewc_r [NUM_ENTRIES];
  logic [WCW-1:0] ewc_nxt [NUM_ENTRIES];
  logic [WCW-1:0] swc_r [NUM_ENTRIES];
  logic [WCW-1:0] swc_nxt [NUM_ENTRIES];

  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  ev_t  out_ev_r, out_ev_nxt;
  id_t  out_who_r, out_who_nxt, out_lk_r, out_lk_nxt;

  // RAM ports
  logic           h_we, e_we, s_we;
  logic [HAW-1:0] h_wa, h_ra, h_base;
  logic [WAW-1:0] e_wa, s_wa, w_ra, w_base;
  id_t            h_wd, e_wd, s_wd, h_rd, e_rd, s_rd, rd_v;

  // lookup and per-entry views
  logic           hit, free_ok;
  logic [EW-1:0]  hit_e, free_e;
  id_t            own_v;
  logic [HCW-1:0] hc_v, room;
  logic [WCW-1:0] ewc_v, swc_v, s2, e2;
  logic [IW-1:0]  mv_cnt, mv_cnt2;
  logic           can, match, idx_end, mv2;

  selm_ram #(.W(16), .D(NUM_ENTRIES * HOLDER_DEPTH)) u_hold (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  selm_ram #(.W(16), .D(NUM_ENTRIES * WAIT_DEPTH)) u_exw (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(w_ra), .rdata(e_rd));
  selm_ram #(.W(16), .D(NUM_ENTRIES * WAIT_DEPTH)) u_shw (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(w_ra), .rdata(s_rd));

  assign h_base = HAW'(e_r) * HAW'(HOLDER_DEPTH);
  assign w_base = WAW'(e_r) * WAW'(WAIT_DEPTH);
  assign h_ra   = h_base + HAW'(idx_r);
  assign w_ra   = w_base + WAW'(idx_r);

  assign can     = !out_valid_r || out_ch.ready;
  assign q_ready = (st_r == S_IDLE);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_res  = out_ev_r;
  assign out_ch.who        = out_who_r;
  assign out_ch.which_lock = out_lk_r;
  assign out_ch.last       = out_last_r;

  // table lookup and decode views
  always_comb begin
    hit     = 1'b0;
    hit_e   = '0;
    free_ok = 1'b0;
    free_e  = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (used_r[i] && key_r[i] == cur_r.lk) begin
        hit   = 1'b1;
        hit_e = EW'(i);
      end
      if (!used_r[i]) begin
        free_ok = 1'b1;
        free_e  = EW'(i);
      end
    end
    own_v = hit_r ? own_r[e_r] : '0;
    hc_v  = hit_r ? hc_r[e_r]  : '0;
    ewc_v = hit_r ? ewc_r[e_r] : '0;
    swc_v = hit_r ? swc_r[e_r] : '0;
    room  = HCW'(HOLDER_DEPTH) - hc_v;
    mv_cnt = (IW'(swc_v) < IW'(room)) ? IW'(swc_v) : IW'(room);
    s2 = swc_v - WCW'(fs_r);
    e2 = ewc_v - WCW'(found_r);
    mv2 = (s2 != '0) && (own_v == '0) && (e2 == '0);
    mv_cnt2 = !mv2 ? '0 : ((IW'(s2) < IW'(room)) ? IW'(s2) : IW'(room));
    unique case (lst_r)
      L_HOLD:  rd_v = h_rd;
      L_EXW:   rd_v = e_rd;
      L_SHW:   rd_v = s_rd;
      default: rd_v = h_rd;
    endcase
    match   = (rd_v == cur_r.id);
    idx_end = (idx_r == end_r);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:      st_nxt = q_valid ? S_DISP : S_IDLE;
      S_DISP:      st_nxt = S_DEC;
      S_DEC:       st_nxt = ((cur_r.kind == K_SUNLOCK || cur_r.kind == K_ABORT) && hit_r)
                            ? S_SCAN_RD : S_ACK;
      S_ACK:       st_nxt = can ? ack_ret_r : S_ACK;
      S_SCAN_RD:   st_nxt = idx_end ? S_SCAN_DONE : S_SCAN_CHK;
      S_SCAN_CHK:  st_nxt = match ? S_SCAN_DONE : S_SCAN_RD;
      S_SCAN_DONE: st_nxt = (cur_r.kind == K_ABORT && lst_r == L_SHW) ? S_SCAN_RD : S_ACK;
      S_SH_RD:     st_nxt = idx_end ? sh_ret_r : S_SH_WR;
      S_SH_WR:     st_nxt = S_SH_RD;
      S_XPOP:      st_nxt = wake_r ? S_XPOP_RD : S_MV;
      S_XPOP_RD:   st_nxt = S_XPOP_W;
      S_XPOP_W:    st_nxt = can ? S_SH_RD : S_XPOP_W;
      S_MV:        st_nxt = S_MV_RD;
      S_MV_RD:     st_nxt = (idx_r == nm_r) ? ((nm_r != '0) ? S_SH_RD : S_FREE) : S_MV_WR;
      S_MV_WR:     st_nxt = can ? S_MV_RD : S_MV_WR;
      S_AB_S:      st_nxt = !fs_r ? S_AB_E : (can ? S_SH_RD : S_AB_S);
      S_AB_E:      st_nxt = !fe_r ? S_MV : (can ? S_SH_RD : S_AB_E);
      S_FREE:      st_nxt = S_IDLE;
      default:     st_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic em, em_last;
    ev_t  em_ev;
    id_t  em_who;
    em = 1'b0; em_last = 1'b0; em_ev = EV_WAKE; em_who = cur_r.id;
    cur_nxt = cur_r; e_nxt = e_r; hit_nxt = hit_r; tf_nxt = tf_r;
    lst_nxt = lst_r; idx_nxt = idx_r; end_nxt = end_r; gap_nxt = gap_r;
    nm_nxt = nm_r; is_nxt = is_r; ie_nxt = ie_r; found_nxt = found_r;
    fs_nxt = fs_r; fe_nxt = fe_r; wake_nxt = wake_r; rem_nxt = rem_r;
    ack_nxt = ack_r; ack_ret_nxt = ack_ret_r; sh_ret_nxt = sh_ret_r;
    used_nxt = used_r; key_nxt = key_r; own_nxt = own_r;
    hc_nxt = hc_r; ewc_nxt = ewc_r; swc_nxt = swc_r;
    h_we = 1'b0; h_wa = h_base + HAW'(hc_v); h_wd = cur_r.id;
    e_we = 1'b0; e_wa = w_base + WAW'(ewc_v); e_wd = cur_r.id;
    s_we = 1'b0; s_wa = w_base + WAW'(swc_v); s_wd = cur_r.id;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
        end
      end
      S_DISP: begin
        e_nxt   = hit ? hit_e : free_e;
        hit_nxt = hit;
        tf_nxt  = !hit && !free_ok;
      end
      S_DEC: begin
        rem_nxt     = '0;
        ack_ret_nxt = S_IDLE;
        ack_nxt     = EV_IGNORED;
        unique case (cur_r.kind)
          K_EXEMPT: ack_nxt = EV_EXEMPT;
          K_SLOCK, K_SREG, K_XLOCK: begin
            if (tf_r) begin
              ack_nxt = EV_TABLE_FULL;
            end else begin
              // fresh entries start empty (views read zero on a miss)
              used_nxt[e_r] = 1'b1;
              key_nxt[e_r]  = cur_r.lk;
              own_nxt[e_r]  = own_v;
              hc_nxt[e_r]   = hc_v;
              ewc_nxt[e_r]  = ewc_v;
              swc_nxt[e_r]  = swc_v;
              if (cur_r.kind == K_XLOCK) begin
                if (hc_v != '0 || (own_v != '0 && own_v != cur_r.id)) begin
                  if (ewc_v >= WCW'(WAIT_DEPTH)) begin
                    ack_nxt = EV_QUEUE_FULL;
                  end else begin
                    e_we = 1'b1;
                    ewc_nxt[e_r] = ewc_v + 1'b1;
                    ack_nxt = EV_QUEUED;
                  end
                end else begin
                  own_nxt[e_r] = cur_r.id;
                  ack_nxt = EV_GRANTED;
                end
              end else if (cur_r.kind == K_SLOCK && (own_v != '0 || ewc_v != '0)) begin
                if (swc_v >= WCW'(WAIT_DEPTH)) begin
                  ack_nxt = EV_QUEUE_FULL;
                end else begin
                  s_we = 1'b1;
                  swc_nxt[e_r] = swc_v + 1'b1;
                  ack_nxt = EV_QUEUED;
                end
              end else if (hc_v >= HCW'(HOLDER_DEPTH)) begin
                ack_nxt = EV_QUEUE_FULL;
              end else begin
                h_we = 1'b1;
                hc_nxt[e_r] = hc_v + 1'b1;
                ack_nxt = EV_GRANTED;
              end
            end
          end
          K_SUNLOCK: begin
            lst_nxt = L_HOLD; idx_nxt = '0; end_nxt = IW'(hc_v); found_nxt = 1'b0;
          end
          K_XUNLOCK: begin
            if (hit_r && own_v == cur_r.id) begin
              ack_nxt      = EV_GRANTED;
              own_nxt[e_r] = '0;
              wake_nxt     = (ewc_v != '0);
              nm_nxt       = mv_cnt;
              rem_nxt      = RMW'(ewc_v != '0) + RMW'(mv_cnt);
              ack_ret_nxt  = S_XPOP;
            end
          end
          K_ABORT: begin
            lst_nxt = L_SHW; idx_nxt = '0; end_nxt = IW'(swc_v); found_nxt = 1'b0;
          end
          default: ack_nxt = EV_IGNORED;
        endcase
      end
      S_ACK: begin
        if (can) begin
          em = 1'b1; em_ev = ack_r; em_last = (rem_r == '0);
        end
      end
      S_SCAN_RD: begin
      end
      S_SCAN_CHK: begin
        if (match) begin
          found_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN_DONE: begin
        if (cur_r.kind == K_SUNLOCK) begin
          ack_nxt = found_r ? EV_GRANTED : EV_IGNORED;
          nm_nxt  = '0;
          if (found_r) begin
            wake_nxt    = (hc_v == HCW'(1)) && (own_v == '0) && (ewc_v != '0);
            rem_nxt     = RMW'((hc_v == HCW'(1)) && (own_v == '0) && (ewc_v != '0));
            idx_nxt     = idx_r + 1'b1;
            gap_nxt     = IW'(1);
            end_nxt     = IW'(hc_v);
            sh_ret_nxt  = S_XPOP;
            ack_ret_nxt = S_SH_RD;
          end else begin
            rem_nxt     = '0;
            ack_ret_nxt = S_IDLE;
          end
        end else if (lst_r == L_SHW) begin
          fs_nxt = found_r; is_nxt = idx_r;
          lst_nxt = L_EXW; idx_nxt = '0; end_nxt = IW'(ewc_v); found_nxt = 1'b0;
        end else begin
          fe_nxt  = found_r; ie_nxt = idx_r;
          nm_nxt  = mv_cnt2;
          rem_nxt = RMW'(fs_r) + RMW'(found_r) + RMW'(mv_cnt2);
          ack_nxt = (fs_r || found_r || mv_cnt2 != '0) ? EV_GRANTED : EV_IGNORED;
          ack_ret_nxt = S_AB_S;
        end
      end
      S_SH_RD: begin
        if (idx_end) begin
          unique case (lst_r)
            L_HOLD:  hc_nxt[e_r]  = hc_v - HCW'(gap_r);
            L_EXW:   ewc_nxt[e_r] = ewc_v - WCW'(gap_r);
            L_SHW:   swc_nxt[e_r] = swc_v - WCW'(gap_r);
            default: hc_nxt[e_r]  = hc_v;
          endcase
        end
      end
      S_SH_WR: begin
        h_wa = h_base + HAW'(idx_r - gap_r); h_wd = rd_v;
        e_wa = w_base + WAW'(idx_r - gap_r); e_wd = rd_v;
        s_wa = w_base + WAW'(idx_r - gap_r); s_wd = rd_v;
        h_we = (lst_r == L_HOLD);
        e_we = (lst_r == L_EXW);
        s_we = (lst_r == L_SHW);
        idx_nxt = idx_r + 1'b1;
      end
      S_XPOP: begin
        lst_nxt = L_EXW; idx_nxt = '0;
      end
      S_XPOP_RD: begin
      end
      S_XPOP_W: begin
        if (can) begin
          own_nxt[e_r] = rd_v;
          em = 1'b1; em_ev = EV_WAKE; em_who = rd_v; em_last = (rem_r == RMW'(1));
          rem_nxt = rem_r - 1'b1;
          lst_nxt = L_EXW; idx_nxt = IW'(1); gap_nxt = IW'(1); end_nxt = IW'(ewc_v);
          sh_ret_nxt = S_MV;
        end
      end
      S_MV: begin
        lst_nxt = L_SHW; idx_nxt = '0;
      end
      S_MV_RD: begin
        if (idx_r == nm_r) begin
          hc_nxt[e_r] = hc_v + HCW'(nm_r);
          gap_nxt = nm_r; end_nxt = IW'(swc_v); sh_ret_nxt = S_FREE;
        end
      end
      S_MV_WR: begin
        if (can) begin
          h_we = 1'b1; h_wa = h_base + HAW'(hc_v) + HAW'(idx_r); h_wd = rd_v;
          em = 1'b1; em_ev = EV_WAKE; em_who = rd_v; em_last = (rem_r == RMW'(1));
          rem_nxt = rem_r - 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_AB_S: begin
        if (fs_r && can) begin
          em = 1'b1; em_ev = EV_ABORTED; em_last = (rem_r == RMW'(1));
          rem_nxt = rem_r - 1'b1;
          lst_nxt = L_SHW; idx_nxt = is_r + 1'b1; gap_nxt = IW'(1); end_nxt = IW'(swc_v);
          sh_ret_nxt = S_AB_E;
        end
      end
      S_AB_E: begin
        if (fe_r && can) begin
          em = 1'b1; em_ev = EV_ABORTED; em_last = (rem_r == RMW'(1));
          rem_nxt = rem_r - 1'b1;
          lst_nxt = L_EXW; idx_nxt = ie_r + 1'b1; gap_nxt = IW'(1); end_nxt = IW'(ewc_v);
          sh_ret_nxt = S_MV;
        end
      end
      S_FREE: begin
        if (hc_v == '0 && own_v == '0 && ewc_v == '0 && swc_v == '0) begin
          used_nxt[e_r] = 1'b0;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = em ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    out_ev_nxt    = em ? em_ev : out_ev_r;
    out_who_nxt   = em ? em_who : out_who_r;
    out_lk_nxt    = em ? cur_r.lk : out_lk_r;
    out_last_nxt  = em ? em_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        used_r[i] <= 1'b0;
        hc_r[i]   <= '0;
        ewc_r[i]  <= '0;
        swc_r[i]  <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      hc_r        <= hc_nxt;
      ewc_r       <= ewc_nxt;
      swc_r       <= swc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; e_r <= e_nxt; hit_r <= hit_nxt; tf_r <= tf_nxt;
    lst_r <= lst_nxt; idx_r <= idx_nxt; end_r <= end_nxt; gap_r <= gap_nxt;
    nm_r <= nm_nxt; is_r <= is_nxt; ie_r <= ie_nxt; found_r <= found_nxt;
    fs_r <= fs_nxt; fe_r <= fe_nxt; wake_r <= wake_nxt; rem_r <= rem_nxt;
    ack_r <= ack_nxt; ack_ret_r <= ack_ret_nxt; sh_ret_r <= sh_ret_nxt;
    key_r <= key_nxt; own_r <= own_nxt;
    out_ev_r <= out_ev_nxt; out_who_r <= out_who_nxt;
    out_lk_r <= out_lk_nxt; out_last_r <= out_last_nxt;
  end

endmodule
